FILE: rtl/core/lru_key_value_cache_unit_defines.svh
// Assertion macros shared by the cache controller and datapath.
// Depends on nothing; included by the files that carry assertions.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKVC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkvc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkvc: next-cycle check failed");

`endif

FILE: rtl/core/lkvc_pkg.sv
// Shared types and constants of the LRU key/value cache.
// Used by the controller, the datapath and the top level.
package lkvc_pkg;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    localparam logic signed [31:0] MISS_VALUE = -32'sd1;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic lookup;
        logic update;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_get;
    } sts_t;

endpackage

FILE: rtl/core/lkvc_ctrl.sv
// Request sequencer of the LRU cache: idle, lookup and update steps,
// plus the response valid flag. Depends on lkvc_pkg and the defines header.
`include "lru_key_value_cache_unit_defines.svh"

module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    output logic rsp_valid,
    input  logic rsp_stall,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;
    logic   finish;
    logic   accept;

    // A get can only retire once the response register is free to take it.
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign finish    = (state_reg == ST_UPDATE) && (!sts.is_get || out_free);
    assign req_stall = !((state_reg == ST_IDLE) || finish);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;

    assign cmd.load_req = accept;
    assign cmd.lookup   = (state_reg == ST_LOOKUP);
    assign cmd.update   = finish;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = (rsp_valid_reg && rsp_stall) || (finish && sts.is_get);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (finish)
                begin
                    state_next = accept ? ST_LOOKUP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    `LKVC_ASSERT_NEXT(a_accept_starts_lookup, clk, rst_n, accept, state_reg == ST_LOOKUP)
    `LKVC_ASSERT_NEXT(a_lookup_then_update, clk, rst_n, state_reg == ST_LOOKUP, state_reg == ST_UPDATE)
    `LKVC_ASSERT_SAME(a_rsp_from_get_update, clk, rst_n, $rose(rsp_valid_reg), $past(finish && sts.is_get))

endmodule

FILE: rtl/core/lkvc_dpath.sv
// Datapath of the LRU cache: key CAM, valid bits, recency ranks, value memory,
// capacity register and response registers. Depends on lkvc_pkg and the defines header.
`include "lru_key_value_cache_unit_defines.svh"

module lkvc_dpath
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  req_t             req_data,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_data,
    output rsp_t             rsp_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]  cap_reg;
    req_t              req_reg;
    logic [31:0]       key_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]  rank_reg [ENTRIES];
    logic [IDX_W-1:0]  rank_next [ENTRIES];
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [31:0]       value_mem [ENTRIES];

    logic              lk_hit_reg;
    logic [IDX_W-1:0]  lk_idx_reg;
    logic [IDX_W-1:0]  lk_rank_reg;
    logic              lk_evict_reg;
    logic [IDX_W-1:0]  lk_victim_reg;

    logic              rsp_hit_reg;
    logic [31:0]       rd_reg;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] victim_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [IDX_W-1:0]  hit_idx, hit_rank, victim_idx, ins_idx;
    logic [IDX_W-1:0]  oldest_rank;
    logic              any_hit;
    logic              evict;
    logic [CMP_W-1:0]  cap_eff;

    logic              is_put;
    logic              miss_ins;
    logic              do_update;

    assign is_put     = (req_reg.req_type == REQ_PUT);
    assign sts.is_get = (req_reg.req_type == REQ_GET);

    // Capacity in use is the register clamped to one and to the entry count.
    always_comb
    begin
        cap_eff = CMP_W'(cap_reg);
        if (cap_eff == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_eff > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
    end

    assign evict       = (CMP_W'(occ_reg) >= cap_eff);
    assign oldest_rank = IDX_W'(occ_reg - CNT_W'(1));

    // Valid ranks always form a permutation of 0..occ-1, and valid keys are
    // unique, so both the match and the victim vectors are at most one-hot.
    always_comb
    begin
        hit_idx    = '0;
        hit_rank   = '0;
        victim_idx = '0;
        ins_idx    = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]      = valid_reg[i] && (key_reg[i] == req_reg.key);
            victim_vec[i] = valid_reg[i] && (rank_reg[i] == oldest_rank);
            if (match[i])
            begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | rank_reg[i];
            end
            if (victim_vec[i])
            begin
                victim_idx = victim_idx | IDX_W'(i);
            end
        end
        free_vec = ~valid_reg | (evict ? victim_vec : '0);
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                ins_idx = IDX_W'(i);
            end
        end
    end

    assign any_hit = |match;

    assign miss_ins  = is_put && !lk_hit_reg;
    assign do_update = cmd.update && (lk_hit_reg || is_put);

    always_comb
    begin
        logic [IDX_W-1:0] iv;
        logic             is_tgt;
        logic             is_vic;
        logic             still_valid;
        iv          = '0;
        is_tgt      = 1'b0;
        is_vic      = 1'b0;
        still_valid = 1'b0;
        valid_next  = valid_reg;
        occ_next    = occ_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (do_update)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                iv          = IDX_W'(i);
                is_tgt      = (iv == lk_idx_reg);
                is_vic      = miss_ins && lk_evict_reg && (iv == lk_victim_reg);
                still_valid = valid_reg[i] && !is_vic;
                valid_next[i] = (is_tgt && miss_ins) ? 1'b1 : still_valid;
                if (is_tgt)
                begin
                    rank_next[i] = '0;
                end
                else if (still_valid && (miss_ins || (rank_reg[i] < lk_rank_reg)))
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
            // An eviction and an insert cancel, so the count only grows.
            if (miss_ins && !lk_evict_reg)
            begin
                occ_next = occ_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_data;
        end
        if (cmd.lookup)
        begin
            lk_hit_reg    <= any_hit;
            lk_idx_reg    <= any_hit ? hit_idx : ins_idx;
            lk_rank_reg   <= hit_rank;
            lk_evict_reg  <= evict;
            lk_victim_reg <= victim_idx;
        end
        if (do_update && miss_ins)
        begin
            key_reg[lk_idx_reg] <= req_reg.key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_update && is_put)
        begin
            value_mem[lk_idx_reg] <= req_reg.value;
        end
        if (cmd.update && sts.is_get)
        begin
            rsp_hit_reg <= lk_hit_reg;
            rd_reg      <= value_mem[lk_idx_reg];
        end
    end

    assign rsp_data.hit        = rsp_hit_reg;
    assign rsp_data.read_value = rsp_hit_reg ? rd_reg : MISS_VALUE;

    `LKVC_ASSERT_SAME(a_match_onehot, clk, rst_n, cmd.lookup, $onehot0(match))
    `LKVC_ASSERT_SAME(a_victim_found, clk, rst_n, cmd.lookup && is_put && !any_hit && evict, $onehot(victim_vec))
    `LKVC_ASSERT_SAME(a_count_bounded, clk, rst_n, 1'b1, occ_reg <= CNT_W'(ENTRIES))
    `LKVC_ASSERT_SAME(a_count_matches_valid, clk, rst_n, 1'b1, CNT_W'($countones(valid_reg)) == occ_reg)

endmodule

FILE: rtl/core/lru_key_value_cache_unit.sv
// Top level of the LRU key/value cache: controller and datapath.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_dpath.
//
// A fully associative cache of ENTRIES key/value pairs with least-recently-used
// replacement. Each request passes through a lookup cycle that compares the
// key against every valid entry in parallel and picks the hit, victim or free
// slot, then an update cycle that applies the recency, valid and value changes.
// The next request is accepted during the update cycle, so its lookup follows
// straight on while the response side keeps up; a get whose response cannot yet
// be taken holds in its update cycle. A get's response is valid the cycle after
// its update cycle; a put gives no response. Valid bits are flip-flops cleared
// at reset, so the cache is usable right after reset. The user must write the
// capacity register only while no request is in flight; it is not enforced.
module lru_key_value_cache_unit
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req_data,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp_data,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    lkvc_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .req_data (req_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .rsp_data (rsp_data)
    );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for lru_key_value_cache_unit.
// Needs lkvc_pkg and the cache RTL; it keeps its own LRU cache model
// to predict every lookup response.
module tb;
    import lkvc_pkg::*;

    localparam int ENTRIES = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;
    logic cfg_we = 1'b0;
    logic [CAP_W-1:0] cfg_data = CAP_RESET;

    // Cache model: slot contents, recency ranks (0 = most recent) and fill level.
    logic signed [31:0] cm_key [ENTRIES];
    logic signed [31:0] cm_value [ENTRIES];
    logic cm_valid [ENTRIES] = '{default: 1'b0};
    logic [3:0] cm_rank [ENTRIES] = '{default: 4'd0};
    int cm_occupied = 0;
    logic [CAP_W-1:0] cm_capacity = CAP_RESET;

    req_t queued_requests [$];
    rsp_t awaited_lookups [$];

    int cycle_count = 0;
    int mismatches = 0;
    int lookups_checked = 0;
    int requests_sent = 0;
    int send_gap = 0;
    bit send_quiet = 1'b0;
    int stall_left = 0;
    int hold_left = 0;
    bit take_quiet = 1'b0;

    lru_key_value_cache_unit #(.ENTRIES(ENTRIES)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Valid slots ranked below the limit age by one; the slot becomes rank 0.
    function automatic void make_most_recent(int slot, int limit);
        for (int i = 0; i < ENTRIES; i++)
            if (i != slot && cm_valid[i] && cm_rank[i] < limit)
                cm_rank[i] = cm_rank[i] + 4'd1;
        cm_rank[slot] = 4'd0;
    endfunction

    function automatic void apply_to_cache_model(req_t r);
        int slot;
        int victim;
        int cap;
        rsp_t res;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && cm_valid[i] && cm_key[i] == r.key)
                slot = i;
        if (r.req_type == REQ_GET)
        begin
            if (slot >= 0)
            begin
                res.hit = 1'b1;
                res.read_value = cm_value[slot];
                make_most_recent(slot, cm_rank[slot]);
            end
            else
            begin
                res.hit = 1'b0;
                res.read_value = MISS_VALUE;
            end
            awaited_lookups.push_back(res);
        end
        else if (slot >= 0)
        begin
            make_most_recent(slot, cm_rank[slot]);
            cm_value[slot] = r.value;
        end
        else
        begin
            cap = (cm_capacity < 1) ? 1 : (cm_capacity > ENTRIES) ? ENTRIES : cm_capacity;
            // A full cache drops its least recent entry, even when the
            // capacity was lowered below the current fill level.
            if (cm_occupied >= cap)
            begin
                victim = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (cm_valid[i] && (victim < 0 || cm_rank[i] > cm_rank[victim]))
                        victim = i;
                if (victim >= 0)
                begin
                    cm_valid[victim] = 1'b0;
                    cm_occupied--;
                end
            end
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && !cm_valid[i])
                    slot = i;
            if (slot >= 0)
            begin
                cm_key[slot] = r.key;
                cm_value[slot] = r.value;
                make_most_recent(slot, 32);
                cm_valid[slot] = 1'b1;
                cm_occupied++;
            end
        end
    endfunction

    task automatic add_request(logic t, logic signed [31:0] k, logic signed [31:0] v);
        req_t r;
        r.req_type = t;
        r.key = k;
        r.value = v;
        queued_requests.push_back(r);
    endtask

    // Keys mostly come from a small pool so that hits, updates and
    // evictions are frequent; the rest are arbitrary.
    task automatic queue_random_phase(int count, int pool_size);
        logic signed [31:0] pool [$];
        req_t r;
        for (int i = 0; i < pool_size; i++)
            pool.push_back($urandom());
        for (int i = 0; i < count; i++)
        begin
            r.req_type = ($urandom_range(0, 1) == 0) ? REQ_GET : REQ_PUT;
            r.key = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_size - 1)]
                                                 : $urandom();
            r.value = $urandom();
            queued_requests.push_back(r);
        end
    endtask

    task automatic wait_for_drain();
        while (queued_requests.size() != 0 || req_valid || awaited_lookups.size() != 0)
            @(posedge clk);
    endtask

    // A put leaves no response behind, so allow the last one to finish.
    task automatic set_capacity(logic [CAP_W-1:0] cap);
        wait_for_drain();
        repeat (6) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= cap;
        cm_capacity = cap;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                apply_to_cache_model(req_data);
                requests_sent++;
                if (requests_sent % 64 == 0)
                    send_quiet = ($urandom_range(0, 3) == 0);
                send_gap = send_quiet ? 0 : pick_gap();
            end
            if (req_valid && req_stall)
            begin
                // Hold the stalled request as it is.
            end
            else if (send_gap == 0 && queued_requests.size() != 0)
            begin
                req_valid <= 1'b1;
                req_data <= queued_requests.pop_front();
            end
            else
            begin
                req_valid <= 1'b0;
                if (send_gap > 0)
                    send_gap--;
            end
        end
    end

    // Response monitor and receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_rsp;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_lookups.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected response: hit=%0b value=%0d",
                                 rsp_data.hit, rsp_data.read_value);
                    mismatches++;
                end
                else
                begin
                    exp_rsp = awaited_lookups.pop_front();
                    if (rsp_data.hit !== exp_rsp.hit ||
                        rsp_data.read_value !== exp_rsp.read_value)
                    begin
                        if (mismatches < 10)
                            $display({"lookup %0d: expected hit=%0b value=%0d,",
                                      " got hit=%0b value=%0d"},
                                     lookups_checked, exp_rsp.hit, exp_rsp.read_value,
                                     rsp_data.hit, rsp_data.read_value);
                        mismatches++;
                    end
                end
                lookups_checked++;
                // Long back-pressure so that a pending get holds and stalls requests.
                if (lookups_checked == 60 || lookups_checked == 400)
                    hold_left = 300;
            end
            if (cycle_count % 256 == 0)
                take_quiet = ($urandom_range(0, 3) == 0);
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (!take_quiet && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        logic [CAP_W-1:0] phase_caps [8];
        phase_caps = '{5'd16, 5'd1, 5'd5, 5'd16, 5'd0, 5'd2, 5'd12, 5'd0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Misses on an empty cache, extreme keys and values, update of a present key.
        add_request(REQ_GET, KEY_MIN, 32'sd0);
        add_request(REQ_GET, KEY_MAX, KEY_MAX);
        add_request(REQ_PUT, KEY_MIN, KEY_MAX);
        add_request(REQ_PUT, KEY_MAX, KEY_MIN);
        add_request(REQ_PUT, 32'sd0, 32'sd0);
        add_request(REQ_PUT, -32'sd1, -32'sd1);
        add_request(REQ_GET, KEY_MAX, 32'sd0);
        add_request(REQ_GET, -32'sd1, 32'sd0);
        add_request(REQ_PUT, KEY_MIN, 32'sd123);
        add_request(REQ_GET, KEY_MIN, 32'sd0);
        add_request(REQ_GET, 32'sd77, 32'sd0);

        // Capacity dropped below the fill level: each new key evicts one entry.
        set_capacity(5'd2);
        add_request(REQ_PUT, 32'sd5, 32'sd55);
        add_request(REQ_GET, 32'sd0, 32'sd0);
        add_request(REQ_GET, 32'sd5, 32'sd0);
        add_request(REQ_PUT, 32'sd6, 32'sd66);
        add_request(REQ_GET, KEY_MAX, 32'sd0);

        set_capacity(5'd1);
        add_request(REQ_PUT, 32'sd7, 32'sd77);
        add_request(REQ_GET, -32'sd1, 32'sd0);
        add_request(REQ_GET, 32'sd7, 32'sd0);
        add_request(REQ_GET, 32'sd5, 32'sd0);
        add_request(REQ_PUT, 32'sd5, KEY_MAX);
        add_request(REQ_GET, 32'sd5, 32'sd0);

        foreach (phase_caps[p])
        begin
            if (phase_caps[p] == 5'd0)
                phase_caps[p] = CAP_W'($urandom_range(1, ENTRIES));
            set_capacity(phase_caps[p]);
            queue_random_phase(100, phase_caps[p] + $urandom_range(1, 6));
        end

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && awaited_lookups.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
